### hw/rtl/wrf_pkg.sv
// Shared types, constants and constant functions of the windowed radix-2 FFT unit.
// Provides the functions from which wrf_datapath builds the window and twiddle tables at elaboration; no dependencies.
package wrf_pkg;

   localparam int POINTS_DEF = 64;
   localparam int ADDR_MAX_W = 6;

   localparam logic [1:0] WIN_RECT     = 2'd0;
   localparam logic [1:0] WIN_HAMMING  = 2'd1;
   localparam logic [1:0] WIN_HANN     = 2'd2;
   localparam logic [1:0] WIN_BLACKMAN = 2'd3;

   localparam logic [0:0] REG_WINDOW_KIND = 1'b0;

   localparam logic [63:0] PI_Q30        = 64'd3373259426;
   localparam longint      ONE_Q30       = 64'sd1073741824;
   localparam longint      C054          = 64'sd579820585;
   localparam longint      C046          = 64'sd493921239;
   localparam longint      C050          = 64'sd536870912;
   localparam longint      C042          = 64'sd450971566;
   localparam longint      C008          = 64'sd85899346;
   localparam longint      INV_SQRT2_Q30 = 64'sd759250125;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic signed [23:0] bin_re;
      logic signed [23:0] bin_im;
      logic [5:0]         bin_number;
      logic               bin_last;
   } rsp_type;

   typedef enum logic [1:0] {
      WSEL_SAMPLE = 2'd0,
      WSEL_ZERO   = 2'd1,
      WSEL_BFLY_A = 2'd2,
      WSEL_BFLY_B = 2'd3
   } wsel_type;

   typedef struct packed {
      logic                  wr_en;
      wsel_type              wr_sel;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic [ADDR_MAX_W-1:0] win_idx;
      logic [ADDR_MAX_W-1:0] rd_addr_a;
      logic [ADDR_MAX_W-1:0] rd_addr_b;
      logic [ADDR_MAX_W-2:0] tw_idx;
      logic                  emit;
      logic [ADDR_MAX_W-1:0] bin_num;
      logic                  bin_last;
   } cmd_type;

   // Cosine in Q30 of a phase given in turns, Q32.
   // The k-th Taylor term is divided by (2k-1)*2k.
   function automatic longint cos_q30(input logic [31:0] phase);
      logic [31:0] p;
      logic        neg;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] prod;
      longint      sum;
      p   = phase;
      neg = 1'b0;
      if (p > 32'h8000_0000) p = 32'h0 - p;
      if (p > 32'h4000_0000) begin
         p   = 32'h8000_0000 - p;
         neg = 1'b1;
      end
      x    = ({32'h0, p} * PI_Q30 + (64'd1 << 30)) >> 31;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = ONE_Q30;
      for (int k = 1; k <= 7; k++) begin
         prod = (term * x2) >> 30;
         case (k)
            1: term = prod / 64'd2;
            2: term = prod / 64'd12;
            3: term = prod / 64'd30;
            4: term = prod / 64'd56;
            5: term = prod / 64'd90;
            6: term = prod / 64'd132;
            default: term = prod / 64'd182;
         endcase
         if ((k & 1) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      return neg ? -sum : sum;
   endfunction

   // Window coefficient, 0 to 32768, for a sample phase in turns.
   function automatic logic [16:0] window_q15(input logic [1:0] kind, input logic [31:0] phase);
      longint c1;
      longint c2;
      longint w60;
      longint r;
      c1 = cos_q30(phase);
      c2 = cos_q30(phase << 1);
      case (kind)
         WIN_HAMMING:  w60 = C054 * ONE_Q30 - C046 * c1;
         WIN_HANN:     w60 = C050 * ONE_Q30 - C050 * c1;
         WIN_BLACKMAN: w60 = C042 * ONE_Q30 - C050 * c1 + C008 * c2;
         default:      return 17'd32768;
      endcase
      r = (w60 + (64'sd1 <<< 44)) >>> 45;
      if (r < 0) r = 0;
      if (r > 32768) r = 32768;
      return r[16:0];
   endfunction

   function automatic longint tw_part(input logic [31:0] phase);
      longint r;
      r = (cos_q30(phase) + 64'sd16384) >>> 15;
      if (r < -32768) r = -32768;
      if (r > 32768) r = 32768;
      return r;
   endfunction

   function automatic logic signed [16:0] tw_re(input logic [31:0] phase);
      longint r;
      r = tw_part(phase);
      return r[16:0];
   endfunction

   function automatic logic signed [16:0] tw_im(input logic [31:0] phase);
      longint r;
      r = -tw_part(phase - 32'h4000_0000);
      return r[16:0];
   endfunction

   // Output scale 1/sqrt(N) in Q30 for N = 2^lg.
   function automatic logic [30:0] scale_q30(input int lg);
      longint r;
      if ((lg & 1) == 1) r = INV_SQRT2_Q30 >>> ((lg - 1) >> 1);
      else r = 64'sd1 <<< (30 - (lg >> 1));
      return r[30:0];
   endfunction

endpackage

### hw/rtl/windowed_radix2_fft_unit.sv
// A frame of N samples is taken one per cycle; after the last one the unit zero pads the rest
// of the frame, runs (N/2)*log2(N) butterflies (read, multiply, sum, write A, write B) on the
// single write port of the work memory, then emits N bins, each after a read and a multiply step.
// busy is high from the last request until the final bin is issued; results cannot be stalled.
// Synchronous active-high reset clears the sequencer, the sample count and window_kind.
// Top level; depends on wrf_pkg, wrf_ctrl and wrf_datapath.
module windowed_radix2_fft_unit
   import wrf_pkg::*;
#(
   parameter int FRAME_POINTS = POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0] kind_ff, kind_in;
   cmd_type    cmd;

   assign pready = 1'b1;

   always_comb begin
      kind_in = kind_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_KIND)) kind_in = pwdata[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) kind_ff <= WIN_RECT;
      else kind_ff <= kind_in;
   end

   assign prdata = (paddr[2] == REG_WINDOW_KIND) ? {30'd0, kind_ff} : 32'd0;

   wrf_ctrl #(
      .FRAME_POINTS(FRAME_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_payload(req_payload),
      .busy       (busy),
      .cmd        (cmd)
   );

   wrf_datapath #(
      .FRAME_POINTS(FRAME_POINTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_payload(req_payload),
      .window_kind(kind_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

endmodule

### hw/rtl/wrf_ctrl.sv
// Sequencer of the windowed FFT: sample intake, zero padding, butterfly passes, bin output.
// Depends on wrf_pkg; drives the datapath through the cmd_type command struct.
module wrf_ctrl
   import wrf_pkg::*;
#(
   parameter int FRAME_POINTS = POINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output cmd_type cmd
);

   localparam int AW = $clog2(FRAME_POINTS);
   localparam int SW = $clog2(AW);
   localparam int BW = AW - 1;
   localparam logic [AW:0]   CNT_FULL  = (AW + 1)'(FRAME_POINTS);
   localparam logic [AW:0]   CNT_PLAST = (AW + 1)'(FRAME_POINTS - 1);
   localparam logic [BW-1:0] BF_LAST   = BW'(FRAME_POINTS / 2 - 1);
   localparam logic [SW-1:0] ST_LAST   = SW'(AW - 1);
   localparam logic [AW-1:0] BIN_LAST  = AW'(FRAME_POINTS - 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_PAD   = 10'b00_0000_0010,
      ST_BRD   = 10'b00_0000_0100,
      ST_BMUL  = 10'b00_0000_1000,
      ST_BSUM  = 10'b00_0001_0000,
      ST_BWRA  = 10'b00_0010_0000,
      ST_BWRB  = 10'b00_0100_0000,
      ST_ORD   = 10'b00_1000_0000,
      ST_OMUL  = 10'b01_0000_0000,
      ST_OEMIT = 10'b10_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [SW-1:0] stage_ff, stage_in;
   logic [BW-1:0] bfly_ff, bfly_in;
   logic [AW-1:0] bin_ff, bin_in;

   logic          accept;
   logic          room;
   logic [AW:0]   cnt_next;
   logic [AW-1:0] half_v;
   logic [AW-1:0] mask_v;
   logic [AW-1:0] bf_ext;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;
   logic [AW-1:0] j_full;
   logic [BW-1:0] tw_v;

   function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      for (int b = 0; b < AW; b++) r[AW-1-b] = v[b];
      return r;
   endfunction

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign room     = (cnt_ff < CNT_FULL);
   assign cnt_next = cnt_ff + (AW + 1)'(room);

   // Decimation in time: butterfly b of a pass pairs i and i + half, where i is b with a
   // zero bit inserted at the position of half.
   assign half_v = AW'(1) << stage_ff;
   assign mask_v = half_v - AW'(1);
   assign bf_ext = AW'(bfly_ff);
   assign addr_a = bf_ext + (bf_ext & ~mask_v);
   assign addr_b = addr_a | half_v;
   assign j_full = bf_ext & mask_v;
   assign tw_v   = j_full[BW-1:0] << (ST_LAST - stage_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      bfly_in  = bfly_ff;
      bin_in   = bin_ff;

      cmd           = '0;
      cmd.wr_sel    = WSEL_SAMPLE;
      cmd.win_idx   = ADDR_MAX_W'(cnt_ff[AW-1:0]);
      cmd.rd_addr_a = ADDR_MAX_W'(addr_a);
      cmd.rd_addr_b = ADDR_MAX_W'(addr_b);
      cmd.tw_idx    = (ADDR_MAX_W - 1)'(tw_v);
      cmd.bin_num   = ADDR_MAX_W'(bin_ff);
      cmd.bin_last  = (bin_ff == BIN_LAST);

      case (state_ff)
         ST_IDLE: begin
            cmd.wr_addr = ADDR_MAX_W'(bitrev(cnt_ff[AW-1:0]));
            if (accept) begin
               cmd.wr_en = room;
               cnt_in    = cnt_next;
               if (req_payload.frame_end) begin
                  if (cnt_next == CNT_FULL) begin
                     state_in = ST_BRD;
                     cnt_in   = '0;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WSEL_ZERO;
            cmd.wr_addr = ADDR_MAX_W'(bitrev(cnt_ff[AW-1:0]));
            if (cnt_ff == CNT_PLAST) begin
               cnt_in   = '0;
               state_in = ST_BRD;
            end else begin
               cnt_in = cnt_ff + (AW + 1)'(1);
            end
         end
         ST_BRD:  state_in = ST_BMUL;
         ST_BMUL: state_in = ST_BSUM;
         ST_BSUM: state_in = ST_BWRA;
         ST_BWRA: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WSEL_BFLY_A;
            cmd.wr_addr = ADDR_MAX_W'(addr_a);
            state_in    = ST_BWRB;
         end
         ST_BWRB: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WSEL_BFLY_B;
            cmd.wr_addr = ADDR_MAX_W'(addr_b);
            if (bfly_ff == BF_LAST) begin
               bfly_in = '0;
               if (stage_ff == ST_LAST) begin
                  stage_in = '0;
                  bin_in   = '0;
                  state_in = ST_ORD;
               end else begin
                  stage_in = stage_ff + SW'(1);
                  state_in = ST_BRD;
               end
            end else begin
               bfly_in  = bfly_ff + BW'(1);
               state_in = ST_BRD;
            end
         end
         ST_ORD: begin
            cmd.rd_addr_a = ADDR_MAX_W'(bin_ff);
            state_in      = ST_OMUL;
         end
         ST_OMUL: begin
            cmd.rd_addr_a = ADDR_MAX_W'(bin_ff);
            state_in      = ST_OEMIT;
         end
         ST_OEMIT: begin
            cmd.rd_addr_a = ADDR_MAX_W'(bin_ff);
            cmd.emit      = 1'b1;
            bin_in        = bin_ff + AW'(1);
            state_in      = (bin_ff == BIN_LAST) ? ST_IDLE : ST_ORD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         stage_ff <= '0;
         bfly_ff  <= '0;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stage_ff <= stage_in;
         bfly_ff  <= bfly_in;
         bin_ff   <= bin_in;
      end
   end

endmodule

### hw/rtl/wrf_datapath.sv
// Datapath of the windowed FFT: work memory, window and twiddle tables, butterfly and scaler.
// Depends on wrf_pkg; follows the cmd_type commands from wrf_ctrl.
module wrf_datapath
   import wrf_pkg::*;
#(
   parameter int FRAME_POINTS = POINTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_payload,
   input  logic [1:0] window_kind,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload
);

   localparam int AW = $clog2(FRAME_POINTS);
   localparam int HALF_POINTS = FRAME_POINTS / 2;
   localparam logic [30:0] SCALE = scale_q30(AW);

   logic [16:0]        win_rom [4][FRAME_POINTS];
   logic signed [16:0] twr_rom [HALF_POINTS];
   logic signed [16:0] twi_rom [HALF_POINTS];

   for (genvar gi = 0; gi < FRAME_POINTS; gi++) begin : g_win
      localparam logic [63:0] PH64 =
         ((64'(gi) << 32) + 64'((FRAME_POINTS - 1) / 2)) / 64'(FRAME_POINTS - 1);
      for (genvar gk = 0; gk < 4; gk++) begin : g_kind
         assign win_rom[gk][gi] = window_q15(2'(gk), PH64[31:0]);
      end
   end

   for (genvar gt = 0; gt < HALF_POINTS; gt++) begin : g_tw
      localparam logic [31:0] TPH = 32'(gt) << (32 - AW);
      assign twr_rom[gt] = tw_re(TPH);
      assign twi_rom[gt] = tw_im(TPH);
   end

   logic [63:0]        mem [FRAME_POINTS];
   logic [63:0]        rd_a_ff, rd_b_ff;
   logic signed [16:0] twr_ff, twi_ff;
   logic signed [48:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [63:0]        sum_a_ff, sum_b_ff;
   logic signed [63:0] s_re_ff, s_im_ff;
   rsp_type            rsp_ff;
   logic               strobe_ff;

   logic [16:0]        win_v;
   logic signed [33:0] wp_re, wp_im;
   logic signed [33:0] wr_re, wr_im;
   logic [63:0]        wdata;
   logic signed [49:0] vr_full, vi_full;
   logic [31:0]        vr, vi;
   logic signed [31:0] b_re, b_im;
   logic [AW-2:0]      tw_a;

   function automatic logic signed [23:0] sat24(input logic signed [63:0] p);
      logic signed [33:0] r;
      r = 34'((p + 64'sd536870912) >>> 30);
      if (r > 34'sd8388607) return 24'sh7FFFFF;
      if (r < -34'sd8388608) return 24'sh800000;
      return r[23:0];
   endfunction

   // Sample windowing, rounded half up to Q1.15.
   assign win_v = win_rom[window_kind][cmd.win_idx[AW-1:0]];
   assign wp_re = req_payload.sample_re * $signed({1'b0, win_v});
   assign wp_im = req_payload.sample_im * $signed({1'b0, win_v});
   assign wr_re = (wp_re + 34'sd16384) >>> 15;
   assign wr_im = (wp_im + 34'sd16384) >>> 15;

   assign vr_full = 50'(p_rr_ff) - 50'(p_ii_ff) + 50'sd16384;
   assign vi_full = 50'(p_ri_ff) + 50'(p_ir_ff) + 50'sd16384;
   assign vr      = 32'(vr_full >>> 15);
   assign vi      = 32'(vi_full >>> 15);
   assign b_re    = rd_b_ff[63:32];
   assign b_im    = rd_b_ff[31:0];
   assign tw_a    = cmd.tw_idx[AW-2:0];

   always_comb begin
      case (cmd.wr_sel)
         WSEL_SAMPLE: wdata = {wr_re[31:0], wr_im[31:0]};
         WSEL_ZERO:   wdata = '0;
         WSEL_BFLY_A: wdata = sum_a_ff;
         WSEL_BFLY_B: wdata = sum_b_ff;
         default:     wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[cmd.wr_addr[AW-1:0]] <= wdata;
      rd_a_ff <= mem[cmd.rd_addr_a[AW-1:0]];
      rd_b_ff <= mem[cmd.rd_addr_b[AW-1:0]];
   end

   // The pipeline runs freely; the sequencer holds its addresses for a whole butterfly.
   always_ff @(posedge clock) begin
      twr_ff   <= twr_rom[tw_a];
      twi_ff   <= twi_rom[tw_a];
      p_rr_ff  <= b_re * twr_ff;
      p_ii_ff  <= b_im * twi_ff;
      p_ri_ff  <= b_re * twi_ff;
      p_ir_ff  <= b_im * twr_ff;
      sum_a_ff <= {rd_a_ff[63:32] + vr, rd_a_ff[31:0] + vi};
      sum_b_ff <= {rd_a_ff[63:32] - vr, rd_a_ff[31:0] - vi};
      s_re_ff  <= $signed(rd_a_ff[63:32]) * $signed({1'b0, SCALE});
      s_im_ff  <= $signed(rd_a_ff[31:0]) * $signed({1'b0, SCALE});
      if (cmd.emit) begin
         rsp_ff.bin_re     <= sat24(s_re_ff);
         rsp_ff.bin_im     <= sat24(s_im_ff);
         rsp_ff.bin_number <= 6'(cmd.bin_num);
         rsp_ff.bin_last   <= cmd.bin_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= cmd.emit;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

### bench/wrf_bin_checker.sv
// Checker for the windowed radix-2 FFT unit: predicts the spectrum bins of every frame
// and compares them with what the unit emits. Depends on wrf_pkg for the payload types.
module wrf_bin_checker
   import wrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_payload,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          bins_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = POINTS_DEF;
   localparam int LOG_N = 6;

   logic [1:0]         win_kind;
   int                 samples_held;
   logic signed [31:0] frame_re [NPTS];
   logic signed [31:0] frame_im [NPTS];
   rsp_type            bin_queue [$];

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Q30 cosine of a Q32 phase in turns, from a folded Taylor series.
   function automatic longint cos_turns(input logic [31:0] phase);
      logic [31:0] p;
      logic        flip;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      p = phase;
      flip = 1'b0;
      if (p > 32'h8000_0000) p = 32'h0 - p;
      if (p > 32'h4000_0000) begin
         p = 32'h8000_0000 - p;
         flip = 1'b1;
      end
      x = ({32'h0, p} * PI_Q30 + (64'd1 << 30)) >> 31;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      acc = ONE_Q30;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k - 1) * 2 * k);
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      acc = clip(acc, 0, ONE_Q30);
      return flip ? -acc : acc;
   endfunction

   function automatic longint window_coef(input logic [1:0] kind, input int idx);
      logic [63:0] num;
      logic [31:0] ph;
      longint      c1;
      longint      c2;
      longint      w60;
      num = (64'(idx) << 32) + 64'((NPTS - 1) / 2);
      ph = 32'(num / 64'(NPTS - 1));
      c1 = cos_turns(ph);
      c2 = cos_turns(ph << 1);
      case (kind)
         WIN_HAMMING:  w60 = C054 * ONE_Q30 - C046 * c1;
         WIN_HANN:     w60 = C050 * ONE_Q30 - C050 * c1;
         WIN_BLACKMAN: w60 = C042 * ONE_Q30 - C050 * c1 + C008 * c2;
         default:      return 32768;
      endcase
      return clip(round_shift(w60, 45), 0, 32768);
   endfunction

   // Pads, transforms in place and queues the scaled bins of the held frame.
   task automatic transform_frame();
      int          rev;
      int          ia;
      int          ib;
      logic [31:0] ph;
      longint      wr;
      longint      wi;
      longint      br;
      longint      bi;
      longint      vr;
      longint      vi;
      longint      ur;
      longint      ui;
      logic signed [31:0] t;
      rsp_type     bin;
      for (int k = samples_held; k < NPTS; k++) begin
         frame_re[k] = '0;
         frame_im[k] = '0;
      end
      for (int i = 0; i < NPTS; i++) begin
         rev = 0;
         for (int b = 0; b < LOG_N; b++) rev |= ((i >> b) & 1) << (LOG_N - 1 - b);
         if (i < rev) begin
            t = frame_re[i]; frame_re[i] = frame_re[rev]; frame_re[rev] = t;
            t = frame_im[i]; frame_im[i] = frame_im[rev]; frame_im[rev] = t;
         end
      end
      for (int len = 2; len <= NPTS; len <<= 1) begin
         for (int i = 0; i < NPTS; i += len) begin
            for (int j = 0; j < len / 2; j++) begin
               ia = i + j;
               ib = i + j + len / 2;
               ph = 32'((64'(j) << 32) / 64'(len));
               wr = clip(round_shift(cos_turns(ph), 15), -32768, 32768);
               wi = -clip(round_shift(cos_turns(ph - 32'h4000_0000), 15), -32768, 32768);
               ur = frame_re[ia];
               ui = frame_im[ia];
               br = frame_re[ib];
               bi = frame_im[ib];
               vr = round_shift(br * wr - bi * wi, 15);
               vi = round_shift(br * wi + bi * wr, 15);
               frame_re[ia] = 32'(ur + vr);
               frame_im[ia] = 32'(ui + vi);
               frame_re[ib] = 32'(ur - vr);
               frame_im[ib] = 32'(ui - vi);
            end
         end
      end
      // With 64 points the scale 1/8 is exactly 2^27 in Q30.
      for (int k = 0; k < NPTS; k++) begin
         bin.bin_re = 24'(clip(round_shift(longint'(frame_re[k]) * (64'sd1 <<< 27), 30),
                               -8388608, 8388607));
         bin.bin_im = 24'(clip(round_shift(longint'(frame_im[k]) * (64'sd1 <<< 27), 30),
                               -8388608, 8388607));
         bin.bin_number = 6'(k);
         bin.bin_last = (k == NPTS - 1);
         bin_queue.push_back(bin);
      end
      samples_held = 0;
   endtask

   task automatic report(input string what);
      $display("%0t: bin mismatch: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      win_kind = WIN_RECT;
      samples_held = 0;
   end

   assign bins_pending = bin_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      longint  w;
      if (reset) begin
         win_kind <= WIN_RECT;
         samples_held = 0;
         bin_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_KIND)
            win_kind <= pwdata[1:0];
         if (start && !busy) begin
            if (samples_held < NPTS) begin
               w = window_coef(win_kind, samples_held);
               frame_re[samples_held] = 32'(round_shift(req_payload.sample_re * w, 15));
               frame_im[samples_held] = 32'(round_shift(req_payload.sample_im * w, 15));
               samples_held++;
            end
            if (req_payload.frame_end) transform_frame();
         end
         if (rsp_strobe) begin
            if (bin_queue.size() == 0) begin
               report($sformatf("unexpected bin %0d", rsp_payload.bin_number));
            end else begin
               want = bin_queue.pop_front();
               if (rsp_payload.bin_re !== want.bin_re)
                  report($sformatf("bin %0d re got %0d want %0d", want.bin_number,
                                   rsp_payload.bin_re, want.bin_re));
               if (rsp_payload.bin_im !== want.bin_im)
                  report($sformatf("bin %0d im got %0d want %0d", want.bin_number,
                                   rsp_payload.bin_im, want.bin_im));
               if (rsp_payload.bin_number !== want.bin_number)
                  report($sformatf("bin number got %0d want %0d", rsp_payload.bin_number,
                                   want.bin_number));
               if (rsp_payload.bin_last !== want.bin_last)
                  report($sformatf("bin %0d last flag got %b want %b", want.bin_number,
                                   rsp_payload.bin_last, want.bin_last));
            end
         end
      end
   end

endmodule

### bench/tb_windowed_radix2_fft_unit.sv
// Top of the windowed radix-2 FFT unit bench: drives frames of sample requests and window
// settings, and gives the verdict. Depends on wrf_pkg, the unit and wrf_bin_checker.
module tb_windowed_radix2_fft_unit;
   import wrf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          bins_pending;
   int          burst_left;
   int          samples_sent;

   windowed_radix2_fft_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   wrf_bin_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
      .bins_pending(bins_pending)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Sends one sample request in bursts with random gaps and holds it until accepted.
   task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                              input logic last);
      int  gap;
      logic taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_payload <= '{sample_re: re, sample_im: im, frame_end: last};
      // busy only changes at rising edges, so its value at the falling edge holds at the next one.
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      samples_sent++;
   endtask

   // Lets the unit finish the frame, then writes the window selection.
   task automatic set_window(input logic [1:0] kind);
      start <= 1'b0;
      @(negedge clock);
      wait (bins_pending == 0);
      repeat (20) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {REG_WINDOW_KIND, 2'b00};
      pwdata <= {30'($urandom_range(0, 32'h3fff_ffff)), kind};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++)
         send_sample(16'($urandom()), 16'($urandom()), i == count - 1);
   endtask

   initial begin
      int          count;
      int          pick;
      int          frames;
      logic [1:0]  kinds [4];
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      samples_sent = 0;
      kinds = '{WIN_RECT, WIN_HAMMING, WIN_HANN, WIN_BLACKMAN};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short frame of extremes under the reset window, then a one-sample frame.
      send_sample(16'h7fff, 16'h7fff, 1'b0);
      send_sample(16'h8000, 16'h8000, 1'b0);
      send_sample(16'h5555, 16'haaaa, 1'b0);
      send_sample(16'h0000, 16'hffff, 1'b1);
      send_sample(16'h8000, 16'h7fff, 1'b1);
      set_window(WIN_BLACKMAN);
      send_frame(8);
      set_window(WIN_HANN);
      send_frame(4);
      set_window(WIN_HAMMING);
      send_frame(5);

      frames = 0;
      while (samples_sent < 420) begin
         set_window(kinds[frames % 4]);
         pick = $urandom_range(0, 9);
         if (pick < 7) count = 64;
         else if (pick < 9) count = $urandom_range(1, 63);
         else count = $urandom_range(65, 72);
         send_frame(count);
         frames++;
      end

      start <= 1'b0;
      @(negedge clock);
      wait (bins_pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("tb_windowed_radix2_fft_unit: PASS");
      else $display("tb_windowed_radix2_fft_unit: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_windowed_radix2_fft_unit: FAIL");
      $finish;
   end

endmodule
